[rtl/core/mvw_pkg.sv]
// Package for the mesh vertex weld/remap block.
// Holds sizes, request codes, the weld item and vertex types and the FSM state type.
// No dependencies.
package mvw_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int FRAC_BITS    = 12;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int COORD_W      = 24;
  localparam int MESH_W       = 8;
  localparam int THR_W        = 16;
  localparam int T2_W         = 2 * THR_W;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int SUM_W        = SQ_W + 2;

  // weld cells in the chain, and pipeline depth from feed read to write-back
  localparam int N_CELLS      = 8;
  localparam int PIPE_LAT     = 2 * N_CELLS + 1;
  localparam int DRAIN_W      = $clog2(PIPE_LAT + 1);

  // 0.005 in Q(FRAC_BITS), rounded
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(((5 << FRAC_BITS) + 500) / 1000);

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FACE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // stored vertex word
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [MESH_W-1:0]         mesh;
  } vtx_t;

  // vertex travelling down the weld chain
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [MESH_W-1:0]         mesh;
    logic                      mapped;
    logic                      claimed;
    logic [IDX_W-1:0]          rep;
  } weld_item_t;

  // control shared by all cells
  typedef struct packed {
    logic            clear;
    logic [T2_W-1:0] t2;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACE_A,
    ST_FACE_B,
    ST_FACE_C,
    ST_READ_W,
    ST_READ_P,
    ST_W_FEED,
    ST_W_DRAIN,
    ST_N_RD,
    ST_N_CHK,
    ST_N_MAP
  } state_t;

endpackage

[rtl/core/mesh_vertex_weld_remap.sv]
// Mesh vertex weld and remap, top level.
// Depends on mvw_pkg, mvw_ram and mvw_chain.
//
// Usage: a request is taken when start is high and busy is low. The result
// comes back on the result ports with done high for exactly one cycle.
// The receiver cannot stall; every result is taken when shown.
// Results by request:
//   load without last_vertex: result in the next cycle, one load per cycle.
//   face remap: three reads of one port (idle, FACE_A, FACE_B), result from FACE_C.
//   read vertex: index read, then vertex read in READ_W, result from READ_P.
//   load with last_vertex: busy through the weld passes, then the result.
//     The weld streams all pending vertices through a row of 8 cells; each
//     pass claims up to 8 representatives, and passes repeat while any is left.
//     Dense renumbering then visits each vertex in turn.
//   bad or unknown requests answer in the next cycle with overflow set.
// Reset clears counts, the weld flag and the threshold (to 20); vertex
// memories are not cleared. weld_threshold is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while the block is idle (not enforced).
module mesh_vertex_weld_remap
  import mvw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic [MESH_W-1:0]         source_mesh,
  input  logic [IDX_W-1:0]          corner_a,
  input  logic [IDX_W-1:0]          corner_b,
  input  logic [IDX_W-1:0]          corner_c,
  input  logic                      last_vertex,
  input  logic                      cfg_wr_en,
  input  logic [THR_W-1:0]          cfg_wr_data,
  output logic                      done,
  output logic [1:0]                result_kind,
  output logic [IDX_W-1:0]          new_a,
  output logic [IDX_W-1:0]          new_b,
  output logic [IDX_W-1:0]          new_c,
  output logic                      degenerate,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [CNT_W-1:0]          unique_count,
  output logic                      overflow
);

  state_t state, state_next;

  logic [CNT_W-1:0]   loaded_count, welded_count;
  logic               weld_done;
  logic [THR_W-1:0]   weld_threshold;
  logic [T2_W-1:0]    t2;
  logic [IDX_W-1:0]   req_b, req_c, face_ra, face_rb;
  logic [IDX_W-1:0]   feed_idx, feed_idx_d, nxt_idx, ren_idx, pend_a;
  logic               feed_v, first_pass, nxt_found, pend_ovf;
  logic [DRAIN_W-1:0] drain_cnt;

  // memory ports
  logic               pos_we;
  logic [IDX_W-1:0]   pos_raddr;
  vtx_t               pos_wdata, pos_rdata;
  logic               rep_we;
  logic [IDX_W-1:0]   rep_raddr;
  logic [IDX_W:0]     rep_wdata, rep_rdata;
  logic               dense_we;
  logic [IDX_W-1:0]   dense_waddr, dense_wdata, dense_raddr, dense_rdata;
  logic               w2o_we;
  logic [IDX_W-1:0]   w2o_raddr, w2o_rdata;

  weld_item_t chain_in, chain_out;
  cell_ctl_t  cell_ctl;
  logic       cell_clear;

  // request decode
  logic             accept, load_fits, face_ok, read_ok, feed_last, ren_last, ren_new;
  logic [CNT_W-1:0] load_base, load_n;

  // result next values
  logic                      emit;
  logic [1:0]                kind_next;
  logic [IDX_W-1:0]          a_next, b_next, c_next;
  logic                      deg_next, ovf_next;
  logic signed [COORD_W-1:0] x_next, y_next, z_next;
  logic [CNT_W-1:0]          uniq_next;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_base = weld_done ? '0 : loaded_count;
  assign load_fits = load_base < CNT_W'(MAX_VERTICES);
  assign load_n    = load_fits ? load_base + 1'b1 : load_base;
  assign face_ok   = weld_done && ({1'b0, corner_a} < loaded_count)
                     && ({1'b0, corner_b} < loaded_count)
                     && ({1'b0, corner_c} < loaded_count);
  assign read_ok   = weld_done && ({1'b0, corner_a} < welded_count);
  assign feed_last = ({1'b0, feed_idx} == loaded_count - 1'b1);
  assign ren_last  = ({1'b0, ren_idx} == loaded_count - 1'b1);
  assign ren_new   = !rep_rdata[IDX_W];

  assign pos_wdata = '{x: pos_x, y: pos_y, z: pos_z, mesh: source_mesh};

  // vertex entering the chain, in the cycle after its memory read
  always_comb begin
    chain_in.valid   = feed_v;
    chain_in.idx     = feed_idx_d;
    chain_in.x       = pos_rdata.x;
    chain_in.y       = pos_rdata.y;
    chain_in.z       = pos_rdata.z;
    chain_in.mesh    = pos_rdata.mesh;
    chain_in.mapped  = !first_pass && rep_rdata[IDX_W];
    chain_in.claimed = 1'b0;
    chain_in.rep     = chain_in.mapped ? rep_rdata[IDX_W-1:0] : feed_idx_d;
  end

  // write back each vertex as it leaves the chain
  assign rep_we    = chain_out.valid;
  assign rep_wdata = {chain_out.mapped, chain_out.rep};

  assign cell_clear = (state_next == ST_W_FEED) && (state != ST_W_FEED);
  assign cell_ctl   = '{clear: cell_clear, t2: t2};

  // next state, memory controls and result values
  always_comb begin
    state_next  = state;
    pos_we      = 1'b0;
    pos_raddr   = feed_idx;
    rep_raddr   = feed_idx;
    dense_raddr = corner_a;
    dense_we    = 1'b0;
    dense_waddr = ren_idx;
    dense_wdata = welded_count[IDX_W-1:0];
    w2o_we      = 1'b0;
    w2o_raddr   = corner_a;
    emit        = 1'b0;
    kind_next   = req_type;
    a_next      = '0;
    b_next      = '0;
    c_next      = '0;
    deg_next    = 1'b0;
    ovf_next    = 1'b0;
    x_next      = '0;
    y_next      = '0;
    z_next      = '0;
    uniq_next   = welded_count;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_LOAD: begin
              pos_we = load_fits;
              if (last_vertex && (load_n != '0)) begin
                state_next = ST_W_FEED;
              end else begin
                emit      = 1'b1;
                a_next    = load_fits ? load_base[IDX_W-1:0] : '0;
                ovf_next  = !load_fits;
                uniq_next = weld_done ? '0 : welded_count;
              end
            end
            REQ_FACE: begin
              if (face_ok) begin
                state_next = ST_FACE_A;
              end else begin
                emit     = 1'b1;
                deg_next = 1'b1;
                ovf_next = 1'b1;
              end
            end
            REQ_READ: begin
              if (read_ok) begin
                state_next = ST_READ_W;
              end else begin
                emit     = 1'b1;
                ovf_next = 1'b1;
              end
            end
            default: begin
              emit     = 1'b1;
              ovf_next = 1'b1;
            end
          endcase
        end
      end
      ST_FACE_A: begin
        dense_raddr = req_b;
        state_next  = ST_FACE_B;
      end
      ST_FACE_B: begin
        dense_raddr = req_c;
        state_next  = ST_FACE_C;
      end
      ST_FACE_C: begin
        emit       = 1'b1;
        kind_next  = REQ_FACE;
        a_next     = face_ra;
        b_next     = face_rb;
        c_next     = dense_rdata;
        deg_next   = (face_ra == face_rb) || (face_rb == dense_rdata)
                     || (dense_rdata == face_ra);
        state_next = ST_IDLE;
      end
      ST_READ_W: begin
        pos_raddr  = w2o_rdata;
        state_next = ST_READ_P;
      end
      ST_READ_P: begin
        emit       = 1'b1;
        kind_next  = REQ_READ;
        x_next     = pos_rdata.x;
        y_next     = pos_rdata.y;
        z_next     = pos_rdata.z;
        state_next = ST_IDLE;
      end
      ST_W_FEED: begin
        if (feed_last) begin
          state_next = ST_W_DRAIN;
        end
      end
      ST_W_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = nxt_found ? ST_W_FEED : ST_N_RD;
        end
      end
      ST_N_RD: begin
        rep_raddr  = ren_idx;
        state_next = ST_N_CHK;
      end
      ST_N_CHK: begin
        if (ren_new) begin
          dense_we   = 1'b1;
          w2o_we     = 1'b1;
          state_next = ren_last ? ST_IDLE : ST_N_RD;
          uniq_next  = welded_count + 1'b1;
          emit       = ren_last;
        end else begin
          dense_raddr = rep_rdata[IDX_W-1:0];
          state_next  = ST_N_MAP;
        end
        kind_next = REQ_LOAD;
        a_next    = pend_a;
        ovf_next  = pend_ovf;
      end
      ST_N_MAP: begin
        dense_we    = 1'b1;
        dense_wdata = dense_rdata;
        state_next  = ren_last ? ST_IDLE : ST_N_RD;
        emit        = ren_last;
        kind_next   = REQ_LOAD;
        a_next      = pend_a;
        ovf_next    = pend_ovf;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      welded_count   <= '0;
      weld_done      <= 1'b0;
      weld_threshold <= THR_RESET;
      done           <= 1'b0;
      feed_v         <= 1'b0;
      nxt_found      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weld_threshold <= cfg_wr_data;
      end
      done   <= emit;
      feed_v <= (state == ST_W_FEED);

      // next pass starts at the first vertex left neither claimed nor mapped
      if (cell_clear) begin
        nxt_found <= 1'b0;
      end else if (chain_out.valid && !chain_out.mapped && !chain_out.claimed
                   && !nxt_found) begin
        nxt_found <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (req_type == REQ_LOAD)) begin
            loaded_count <= load_n;
            welded_count <= weld_done ? '0 : welded_count;
            weld_done    <= last_vertex && (load_n == '0);
          end
        end
        ST_W_DRAIN: begin
          if ((drain_cnt == '0) && !nxt_found) begin
            welded_count <= '0;
          end
        end
        ST_N_CHK: begin
          if (ren_new) begin
            welded_count <= welded_count + 1'b1;
            weld_done    <= ren_last;
          end
        end
        ST_N_MAP: begin
          weld_done <= ren_last;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    t2         <= T2_W'(weld_threshold) * T2_W'(weld_threshold);
    feed_idx_d <= feed_idx;
    if (chain_out.valid && !chain_out.mapped && !chain_out.claimed && !nxt_found) begin
      nxt_idx <= chain_out.idx;
    end
    if (emit) begin
      result_kind  <= kind_next;
      new_a        <= a_next;
      new_b        <= b_next;
      new_c        <= c_next;
      degenerate   <= deg_next;
      overflow     <= ovf_next;
      out_x        <= x_next;
      out_y        <= y_next;
      out_z        <= z_next;
      unique_count <= uniq_next;
    end
    case (state)
      ST_IDLE: begin
        req_b    <= corner_b;
        req_c    <= corner_c;
        pend_a   <= load_fits ? load_base[IDX_W-1:0] : '0;
        pend_ovf <= !load_fits;
        feed_idx <= '0;
        first_pass <= 1'b1;
      end
      ST_FACE_A: face_ra <= dense_rdata;
      ST_FACE_B: face_rb <= dense_rdata;
      ST_W_FEED: begin
        if (feed_last) begin
          drain_cnt <= DRAIN_W'(PIPE_LAT);
        end else begin
          feed_idx <= feed_idx + 1'b1;
        end
      end
      ST_W_DRAIN: begin
        drain_cnt <= drain_cnt - 1'b1;
        if (drain_cnt == '0) begin
          feed_idx   <= nxt_idx;
          first_pass <= 1'b0;
          ren_idx    <= '0;
        end
      end
      ST_N_CHK: begin
        if (ren_new && !ren_last) begin
          ren_idx <= ren_idx + 1'b1;
        end
      end
      ST_N_MAP: begin
        if (!ren_last) begin
          ren_idx <= ren_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // vertex store: coordinates and source mesh
  mvw_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (load_base[IDX_W-1:0]),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // representative per vertex, with mapped flag
  mvw_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_VERTICES)) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr (chain_out.idx),
    .wdata (rep_wdata),
    .raddr (rep_raddr),
    .rdata (rep_rdata)
  );

  // original index to dense welded index
  mvw_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  // welded index to original index
  mvw_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_w2o_ram (
    .clk   (clk),
    .we    (w2o_we),
    .waddr (welded_count[IDX_W-1:0]),
    .wdata (ren_idx),
    .raddr (w2o_raddr),
    .rdata (w2o_rdata)
  );

  mvw_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cell_ctl),
    .item_in  (chain_in),
    .item_out (chain_out)
  );

`ifndef SYNTHESIS
  // no result while the weld stream runs
  a_no_result_in_feed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_FEED) |-> !done)
    else $error("result during weld feed");

  // write-back only for loaded vertices
  a_writeback_in_range: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> ({1'b0, chain_out.idx} < loaded_count))
    else $error("weld write-back beyond loaded count");

  // welded vertices never outnumber loaded ones
  a_welded_le_loaded: assert property (@(posedge clk) disable iff (rst)
    weld_done |-> (welded_count <= loaded_count))
    else $error("welded count above loaded count");
`endif

endmodule

[rtl/core/mvw_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/mvw_cell.sv]
// One weld cell: holds one representative vertex and tests passing vertices.
// Depends on mvw_pkg.
module mvw_cell
  import mvw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  weld_item_t item_in,
  output weld_item_t item_out
);

  logic                      full;
  logic [IDX_W-1:0]          own_idx;
  logic signed [COORD_W-1:0] own_x, own_y, own_z;
  logic [MESH_W-1:0]         own_mesh;

  weld_item_t    a_item, a_item_next, out_next;
  logic          a_cmp;
  logic [SQ_W-1:0] sqx, sqy, sqz;

  logic eligible, claim;
  logic signed [COORD_W:0]     dx, dy, dz;
  logic signed [2*COORD_W+1:0] px, py, pz;
  logic [SUM_W-1:0]            dist2;
  logic                        hit;

  // stage A: claim when empty, otherwise square the differences
  assign eligible = item_in.valid && !item_in.mapped && !item_in.claimed;
  assign claim    = eligible && !full;
  assign dx = {item_in.x[COORD_W-1], item_in.x} - {own_x[COORD_W-1], own_x};
  assign dy = {item_in.y[COORD_W-1], item_in.y} - {own_y[COORD_W-1], own_y};
  assign dz = {item_in.z[COORD_W-1], item_in.z} - {own_z[COORD_W-1], own_z};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // stage B: sum and threshold test
  assign dist2 = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  assign hit   = a_cmp && (dist2 <= SUM_W'(ctl.t2));

  // next values of the two item stages
  always_comb begin
    a_item_next         = item_in;
    a_item_next.claimed = item_in.claimed | claim;
    out_next            = a_item;
    if (hit) begin
      out_next.mapped = 1'b1;
      out_next.rep    = own_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      full           <= 1'b0;
      a_item.valid   <= 1'b0;
      item_out.valid <= 1'b0;
      a_cmp          <= 1'b0;
    end else begin
      if (claim) begin
        full     <= 1'b1;
        own_idx  <= item_in.idx;
        own_x    <= item_in.x;
        own_y    <= item_in.y;
        own_z    <= item_in.z;
        own_mesh <= item_in.mesh;
      end
      a_item   <= a_item_next;
      a_cmp    <= eligible && full && (item_in.mesh != own_mesh);
      item_out <= out_next;
    end
  end

  // squares carry no control
  always_ff @(posedge clk) begin
    sqx <= px[SQ_W-1:0];
    sqy <= py[SQ_W-1:0];
    sqz <= pz[SQ_W-1:0];
  end

endmodule

[rtl/core/mvw_chain.sv]
// Row of weld cells; each vertex passes every cell in index order.
// Depends on mvw_pkg and mvw_cell.
module mvw_chain
  import mvw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  weld_item_t item_in,
  output weld_item_t item_out
);

  weld_item_t link [N_CELLS+1];

  assign link[0]  = item_in;
  assign item_out = link[N_CELLS];

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    mvw_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .item_in  (link[g]),
      .item_out (link[g+1])
    );
  end

endmodule

[tb/tb.sv]
// Testbench for mesh_vertex_weld_remap: directed and random load, face and read requests.
// Checks each result against an in-bench weld predictor; depends on mvw_pkg and the RTL.
module tb;
  import mvw_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   a, b, c;
    logic               degen;
    logic [COORD_W-1:0] x, y, z;
    logic [CNT_W-1:0]   count;
    logic               ovf;
  } weld_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_LOAD;
  logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [MESH_W-1:0] source_mesh = '0;
  logic [IDX_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic last_vertex = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  logic done;
  logic [1:0] result_kind;
  logic [IDX_W-1:0] new_a, new_b, new_c;
  logic degenerate;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic [CNT_W-1:0] unique_count;
  logic overflow;

  mesh_vertex_weld_remap uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .source_mesh(source_mesh),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .last_vertex(last_vertex), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .result_kind(result_kind), .new_a(new_a), .new_b(new_b),
    .new_c(new_c), .degenerate(degenerate), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .unique_count(unique_count), .overflow(overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [COORD_W-1:0] vx [MAX_VERTICES];
  logic signed [COORD_W-1:0] vy [MAX_VERTICES];
  logic signed [COORD_W-1:0] vz [MAX_VERTICES];
  logic [MESH_W-1:0] vmesh [MAX_VERTICES];
  int unsigned remap [MAX_VERTICES];
  int unsigned rep_orig [MAX_VERTICES];
  int unsigned n_loaded = 0, n_welded = 0;
  bit welded = 0;
  logic [THR_W-1:0] thresh = THR_RESET;

  weld_result_t pending_q[$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit pace_on = 1;
  bit start_hi = 0;
  int idle_cycles = 0;

  function automatic longint sqd(logic signed [COORD_W-1:0] p, logic signed [COORD_W-1:0] q);
    longint d;
    d = longint'(p) - longint'(q);
    return d * d;
  endfunction

  // greedy weld then dense renumbering
  function automatic void weld_batch();
    longint t2, d2;
    t2 = longint'(thresh) * longint'(thresh);
    for (int i = 0; i < n_loaded; i++) remap[i] = i;
    for (int i = 0; i < n_loaded; i++) begin
      if (remap[i] != i) continue;
      for (int j = i + 1; j < n_loaded; j++) begin
        if (vmesh[j] == vmesh[i] || remap[j] != j) continue;
        d2 = sqd(vx[j], vx[i]) + sqd(vy[j], vy[i]) + sqd(vz[j], vz[i]);
        if (d2 <= t2) remap[j] = i;
      end
    end
    n_welded = 0;
    for (int i = 0; i < n_loaded; i++) begin
      if (remap[i] == i) begin
        rep_orig[n_welded] = i;
        remap[i] = n_welded;
        n_welded++;
      end else begin
        remap[i] = remap[remap[i]];
      end
    end
    welded = 1;
  endfunction

  function automatic weld_result_t predict_request();
    weld_result_t r;
    int unsigned ra, rb, rc, o;
    r = '{kind: req_type, a: '0, b: '0, c: '0, degen: 0, x: '0, y: '0, z: '0,
          count: '0, ovf: 0};
    case (req_type)
      REQ_LOAD: begin
        if (welded) begin
          n_loaded = 0;
          n_welded = 0;
          welded = 0;
        end
        if (n_loaded < MAX_VERTICES) begin
          vx[n_loaded] = pos_x;
          vy[n_loaded] = pos_y;
          vz[n_loaded] = pos_z;
          vmesh[n_loaded] = source_mesh;
          r.a = IDX_W'(n_loaded);
          n_loaded++;
        end else begin
          r.ovf = 1;
        end
        if (last_vertex) weld_batch();
      end
      REQ_FACE: begin
        if (!welded || corner_a >= n_loaded || corner_b >= n_loaded || corner_c >= n_loaded)
        begin
          r.degen = 1;
          r.ovf = 1;
        end else begin
          ra = remap[corner_a];
          rb = remap[corner_b];
          rc = remap[corner_c];
          r.a = IDX_W'(ra);
          r.b = IDX_W'(rb);
          r.c = IDX_W'(rc);
          r.degen = (ra == rb || rb == rc || rc == ra);
        end
      end
      REQ_READ: begin
        if (!welded || corner_a >= n_welded) begin
          r.ovf = 1;
        end else begin
          o = rep_orig[corner_a];
          r.x = vx[o];
          r.y = vy[o];
          r.z = vz[o];
        end
      end
      default: r.ovf = 1;
    endcase
    r.count = CNT_W'(n_welded);
    return r;
  endfunction

  // request and register-write monitor
  always @(posedge clk) begin
    if (!rst && start && !busy) pending_q.insert(pending_q.size(), predict_request());
    if (!rst && cfg_wr_en) thresh = cfg_wr_data;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    weld_result_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result kind", result_kind, 0);
      end else begin
        e = pending_q.pop_front();
        if (result_kind !== e.kind) report_mismatch("result_kind", result_kind, e.kind);
        if (new_a !== e.a) report_mismatch("new_a", new_a, e.a);
        if (new_b !== e.b) report_mismatch("new_b", new_b, e.b);
        if (new_c !== e.c) report_mismatch("new_c", new_c, e.c);
        if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
        if (unique_count !== e.count) report_mismatch("unique_count", unique_count, e.count);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mesh_vertex_weld_remap test failed");
      $finish;
    end
  end

  // send one request, then maybe open a gap before the next burst
  task automatic send_req(logic [1:0] kind, logic signed [COORD_W-1:0] x,
                          logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                          logic [MESH_W-1:0] mesh, logic [IDX_W-1:0] a,
                          logic [IDX_W-1:0] b, logic [IDX_W-1:0] c, logic last);
    req_type <= kind;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    source_mesh <= mesh;
    corner_a <= a;
    corner_b <= b;
    corner_c <= c;
    last_vertex <= last;
    start <= 1'b1;
    start_hi = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (pace_on && burst_left <= 0) begin
      start <= 1'b0;
      start_hi = 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_vtx(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                          logic signed [COORD_W-1:0] z, logic [MESH_W-1:0] mesh,
                          logic last);
    send_req(REQ_LOAD, x, y, z, mesh, IDX_W'($urandom), IDX_W'($urandom),
             IDX_W'($urandom), last);
  endtask

  task automatic face_req(int unsigned a, int unsigned b, int unsigned c);
    send_req(REQ_FACE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
             MESH_W'($urandom), IDX_W'(a), IDX_W'(b), IDX_W'(c), 1'($urandom));
  endtask

  task automatic read_req(int unsigned a);
    send_req(REQ_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
             MESH_W'($urandom), IDX_W'(a), IDX_W'($urandom), IDX_W'($urandom),
             1'($urandom));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_wait();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 0;
    end
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_thresh(logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // faces, reads and bad requests before any weld has run
  task automatic test_before_weld();
    face_req(0, 0, 0);
    read_req(0);
    send_req(REQ_BAD, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    load_vtx(24'sd5, 24'sd5, 24'sd5, 8'd0, 1'b0);
    face_req(0, 0, 0);
    drain_wait();
  endtask

  // small batch at the coordinate extremes, default threshold
  task automatic test_directed_weld();
    load_vtx(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 8'd0, 1'b0);
    load_vtx(24'sh7FFFF0, 24'sh7FFFFF, 24'sh7FFFFF, 8'd255, 1'b0);
    load_vtx(24'sh800000, 24'sh800000, 24'sh800000, 8'd1, 1'b0);
    load_vtx(24'sh800000, 24'sh800000, 24'sh800000, 8'd1, 1'b0);
    load_vtx(24'sh80000B, 24'sh80000B, 24'sh800000, 8'd2, 1'b0);
    load_vtx(24'sd0, 24'sd0, 24'sd0, 8'd7, 1'b1);
    face_req(0, 1, 2);
    face_req(2, 3, 4);
    face_req(5, 0, 4);
    face_req(0, 1, 1023);
    face_req(6, 0, 0);
    read_req(0);
    read_req(3);
    read_req(4);
    read_req(1023);
    send_req(REQ_BAD, '1, '1, '1, '1, '1, '1, '1, 1'b1);
    drain_wait();
  endtask

  // fill past capacity; the dropped load carries last_vertex
  task automatic test_capacity();
    pace_on = 0;
    for (int i = 0; i <= MAX_VERTICES; i++)
      load_vtx(24'sd100, -24'sd100, 24'sd3, MESH_W'(i), i == MAX_VERTICES);
    pace_on = 1;
    face_req(0, 1, 1023);
    face_req(0, 256, 512);
    read_req(3);
    read_req(4);
    drain_wait();
  endtask

  // clustered batch with random faces and reads mixed in
  task automatic random_batch(int n, int jit, int mesh_span);
    logic signed [COORD_W-1:0] bx, by, bz;
    int faces;
    for (int i = 0; i < n; i++) begin
      if (i % 3 == 0 || $urandom_range(0, 9) == 0) begin
        bx = COORD_W'($urandom) >>> $urandom_range(0, 2);
        by = COORD_W'($urandom) >>> $urandom_range(0, 2);
        bz = COORD_W'($urandom) >>> $urandom_range(0, 2);
      end
      if ($urandom_range(0, 19) == 0) begin
        load_vtx(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 MESH_W'($urandom), i == n - 1);
      end else begin
        load_vtx(COORD_W'(bx + $signed($urandom_range(0, 2 * jit)) - jit),
                 COORD_W'(by + $signed($urandom_range(0, 2 * jit)) - jit),
                 COORD_W'(bz + $signed($urandom_range(0, 2 * jit)) - jit),
                 MESH_W'($urandom_range(0, mesh_span)), i == n - 1);
      end
    end
    faces = $urandom_range(n, 2 * n);
    for (int k = 0; k < faces; k++) begin
      case ($urandom_range(0, 9))
        0: read_req($urandom_range(0, 1023));
        1, 2, 3: read_req($urandom_range(0, n));
        4: face_req($urandom_range(0, 1023), $urandom_range(0, n), $urandom_range(0, n));
        5: send_req(REQ_BAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    MESH_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                    IDX_W'($urandom), 1'($urandom));
        default: face_req($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1));
      endcase
    end
  endtask

  // random batches over several threshold settings
  task automatic test_random();
    logic [THR_W-1:0] th;
    int phase;
    phase = 0;
    while (items_sent < 1800) begin
      case (phase % 5)
        0: th = '0;
        1: th = '1;
        2: th = THR_RESET;
        3: th = 16'd1000;
        default: th = THR_W'($urandom);
      endcase
      write_thresh(th);
      pace_on = (phase % 4 != 3);
      for (int b = 0; b < 4; b++)
        random_batch($urandom_range(1, 40), th + 2, $urandom_range(0, 3));
      drain_wait();
      phase++;
    end
    pace_on = 1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_weld();
    test_directed_weld();
    test_capacity();
    test_random();
    drain_wait();
    if (errors == 0) begin
      $display("mesh_vertex_weld_remap test passed");
    end else begin
      $display("mesh_vertex_weld_remap test failed");
    end
    $finish;
  end

endmodule
